### hdl/ias_pkg.sv
// Shared types, constants and compare helpers for the index argsort block.
package ias_pkg;

  localparam int VAL_W     = 32;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DESCENDING   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BY_MAGNITUDE = 1'd1;

  localparam logic signed [VAL_W-1:0] KEY_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] KEY_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_PREP,
    OP_SORT,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] key;
    logic [IDX_W-1:0]        idx;
  } cell_t;

  typedef struct packed {
    cell_op_t                op;
    logic                    phase;
    logic                    descending;
    logic                    by_magnitude;
    logic [IDX_W-1:0]        ptr;
    logic signed [VAL_W-1:0] value;
  } ctl_t;

  function automatic logic signed [VAL_W-1:0] abs_sat(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v == KEY_MIN) r = KEY_MAX;
    else if (v < 0) r = -v;
    else r = v;
    return r;
  endfunction

  // true when a belongs ahead of b; equal keys order by lower index
  function automatic logic goes_before(input cell_t a, input cell_t b, input logic desc);
    logic tie;
    logic ahead;
    tie   = (a.key == b.key) && (a.idx < b.idx);
    ahead = desc ? (a.key > b.key) : (a.key < b.key);
    return ahead || tie;
  endfunction

endpackage

### hdl/ias_stream_ifs.sv
// Valid/ready stream interfaces for element and rank transactions.
interface ias_elem_if import ias_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

interface ias_rank_if import ias_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic             last_out;

  modport source (output valid, output index, output last_out, input ready);
  modport sink (input valid, input index, input last_out, output ready);
endinterface

### hdl/ias_cell.sv
// One sorter cell: holds a key and its index, compare-exchanges with its neighbors.
module ias_cell import ias_pkg::*; #(
  parameter int ID = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl,
  input  cell_t left_d,
  input  cell_t right_d,
  input  logic  swap_in,
  output logic  swap_out,
  output cell_t q
);

  localparam logic PAR = 1'(ID % 2);

  cell_t q_next;

  assign swap_out = (ctl.op == OP_SORT) && (PAR == ctl.phase) && q.valid && right_d.valid &&
                    goes_before(right_d, q, ctl.descending);

  always_comb begin
    q_next = q;
    case (ctl.op)
      OP_LOAD: begin
        if (ctl.ptr == IDX_W'(ID)) begin
          q_next.valid = 1'b1;
          q_next.key   = ctl.value;
          q_next.idx   = ctl.ptr;
        end
      end
      OP_PREP: begin
        if (ctl.by_magnitude) q_next.key = abs_sat(q.key);
      end
      OP_SORT: begin
        if (swap_out) q_next = right_d;
        else if (swap_in) q_next = left_d;
      end
      OP_SHIFT: q_next = right_d;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

endmodule

### hdl/index_argsort_by_value.sv
// Top level: loads a vector into a cell chain, sorts it in place, streams out indices.
//
//  channel   dir   payload             handshake
//  elem      in    value, last_in      valid/ready
//  rank      out   index, last_out     valid/ready
//  wr_*      in    wr_index, wr_data   wr_en, no stall
//
// A vector of n elements is loaded, has its keys prepared, goes through
// n odd-even transposition phases across the cell chain, then streams out n indices.
// The chain holds one vector; elem.ready stays low from the end of a vector
// until its last index is taken. Output stalls freeze the chain.
// Reset clears the cell valid bits, the counters and both registers.
module index_argsort_by_value import ias_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  ias_elem_if.sink             elem,
  ias_rank_if.source           rank,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [1:0] {
    S_LOAD,
    S_PREP,
    S_SORT,
    S_DRAIN
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   pass;
  logic            descending;
  logic            by_magnitude;
  ctl_t            ctl;
  cell_t           cells [MAX_ITEMS];
  logic            swaps [MAX_ITEMS];
  logic            elem_xfer;
  logic            rank_xfer;

  assign elem.ready = (state == S_LOAD);
  assign elem_xfer  = elem.valid && elem.ready;
  assign rank.valid = (state == S_DRAIN);
  assign rank.index    = cells[0].idx;
  assign rank.last_out = (count == CW'(1));
  assign rank_xfer  = rank.valid && rank.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending   <= 1'b0;
      by_magnitude <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DESCENDING:   descending   <= wr_data[0];
        REG_BY_MAGNITUDE: by_magnitude <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctl.op           = OP_HOLD;
    ctl.phase        = pass[0];
    ctl.descending   = descending;
    ctl.by_magnitude = by_magnitude;
    ctl.ptr          = IDX_W'(count);
    ctl.value        = elem.value;
    unique case (state)
      S_LOAD:  if (elem_xfer) ctl.op = OP_LOAD;
      S_PREP:  ctl.op = OP_PREP;
      S_SORT:  ctl.op = OP_SORT;
      S_DRAIN: if (rank_xfer) ctl.op = OP_SHIFT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      pass  <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (elem_xfer) begin
            count <= count + CW'(1);
            if (elem.last_in || count == CW'(MAX_ITEMS - 1)) state <= S_PREP;
          end
        end
        S_PREP: begin
          pass  <= '0;
          state <= S_SORT;
        end
        S_SORT: begin
          pass <= pass + CW'(1);
          if (pass == count - CW'(1)) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (rank_xfer) begin
            count <= count - CW'(1);
            if (count == CW'(1)) state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t left_d;
    cell_t right_d;
    logic  swap_in;

    if (i == 0) begin : g_first
      assign left_d  = '0;
      assign swap_in = 1'b0;
    end else begin : g_mid
      assign left_d  = cells[i-1];
      assign swap_in = swaps[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cells[i+1];
    end

    ias_cell #(.ID(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .left_d   (left_d),
      .right_d  (right_d),
      .swap_in  (swap_in),
      .swap_out (swaps[i]),
      .q        (cells[i])
    );
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(elem.ready && rank.valid))
    else $error("input and output open together");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> cells[0].valid)
    else $error("result offered from an empty cell");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (rank_xfer && rank.last_out) |=> (elem.ready && !cells[0].valid))
    else $error("chain not drained after last result");

endmodule

### sim/ias_checker.sv
// Watches the element, rank and register ports, predicts the sorted indices and compares.
module ias_checker import ias_pkg::*; #(
  parameter int CAP = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 elem_valid,
  input  logic                 elem_ready,
  input  logic [VAL_W-1:0]     elem_value,
  input  logic                 elem_last,
  input  logic                 rank_valid,
  input  logic                 rank_ready,
  input  logic [IDX_W-1:0]     rank_index,
  input  logic                 rank_last,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [VAL_W:0] MAG_SAT = {2'b00, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } rank_exp_t;

  rank_exp_t        rank_q[$];
  logic [VAL_W-1:0] elem_vals[CAP];
  int               held;
  logic             desc_r;
  logic             mag_r;
  int               fails;
  int               n_checked;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    fails      = 0;
    n_checked  = 0;
    held       = 0;
    desc_r     = 1'b0;
    mag_r      = 1'b0;
  end

  function automatic logic signed [VAL_W:0] order_key(input logic [VAL_W-1:0] raw,
                                                      input logic mag);
    logic signed [VAL_W:0] s;
    s = signed'({raw[VAL_W-1], raw});
    if (mag) begin
      if (s < 0) s = -s;
      if (s > MAG_SAT) s = MAG_SAT;
    end
    return s;
  endfunction

  function automatic logic ahead_of(input logic signed [VAL_W:0] a,
                                    input logic signed [VAL_W:0] b, input logic desc);
    return desc ? (a > b) : (a < b);
  endfunction

  // stable insertion sort of load positions, strict compare keeps lower index first on ties
  task automatic rank_vector(input int n);
    int                    slot[CAP];
    int                    i;
    int                    j;
    logic signed [VAL_W:0] k;
    rank_exp_t             e;
    for (i = 0; i < n; i++) begin
      j = i;
      k = order_key(elem_vals[i], mag_r);
      while (j > 0 && ahead_of(k, order_key(elem_vals[slot[j-1]], mag_r), desc_r)) begin
        slot[j] = slot[j-1];
        j--;
      end
      slot[j] = i;
    end
    for (i = 0; i < n; i++) begin
      e.idx  = IDX_W'(slot[i]);
      e.last = (i == n - 1);
      rank_q.push_back(e);
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    fails++;
    $display("mismatch: %s got %0d want %0d at result %0d", what, got, want, n_checked);
  endtask

  always @(posedge clk) begin
    rank_exp_t e;
    if (rst) begin
      rank_q.delete();
      held   = 0;
      desc_r = 1'b0;
      mag_r  = 1'b0;
    end else begin
      if (elem_valid && elem_ready) begin
        elem_vals[held] = elem_value;
        held++;
        if (elem_last || held == CAP) begin
          rank_vector(held);
          held = 0;
        end
      end
      if (rank_valid && rank_ready) begin
        if (rank_q.size() == 0) begin
          report("unexpected index", int'(rank_index), -1);
        end else begin
          e = rank_q.pop_front();
          if (rank_index !== e.idx) report("index", int'(rank_index), int'(e.idx));
          if (rank_last !== e.last) report("last_out", int'(rank_last), int'(e.last));
        end
        n_checked++;
      end
      if (wr_en) begin
        case (wr_index)
          REG_DESCENDING:   desc_r = wr_data[0];
          REG_BY_MAGNITUDE: mag_r  = wr_data[0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending    <= rank_q.size();
    checked    <= n_checked;
  end

endmodule

### sim/tb_index_argsort_by_value.sv
// Testbench top: clock, reset, element and register stimulus, rank backpressure, verdict.
module tb_index_argsort_by_value import ias_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP       = 64;
  localparam int N_ITEMS   = 450;
  localparam int MAX_GAP   = 18;
  localparam int LIMIT     = 400000;
  localparam int SETTLE    = 3 * CAP + 16;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  int fail_count;
  int pending;
  int checked;
  int cycle_count;
  int sent;
  int vectors;
  int phases;
  logic calm;

  ias_elem_if elem_ch ();
  ias_rank_if rank_ch ();

  index_argsort_by_value #(.MAX_ITEMS(CAP)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .elem     (elem_ch),
    .rank     (rank_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  ias_checker #(.CAP(CAP)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_ch.valid),
    .elem_ready (elem_ch.ready),
    .elem_value (elem_ch.value),
    .elem_last  (elem_ch.last_in),
    .rank_valid (rank_ch.valid),
    .rank_ready (rank_ch.ready),
    .rank_index (rank_ch.index),
    .rank_last  (rank_ch.last_out),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d indices outstanding", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value(input int style);
    logic signed [VAL_W-1:0] v;
    case (style)
      0: v = $urandom_range(0, 8) - 4;
      1: begin
        case ($urandom_range(0, 5))
          0: v = KEY_MIN;
          1: v = KEY_MAX;
          2: v = KEY_MIN + 1;
          3: v = 0;
          4: v = -1;
          default: v = 1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // rank side: random stall before each transaction, then hold ready until it is taken
  initial begin
    int gap;
    rank_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        rank_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rank_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rank_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_elem(input logic signed [VAL_W-1:0] v, input logic l);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    elem_ch.valid   <= 1'b1;
    elem_ch.value   <= v;
    elem_ch.last_in <= l;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic drain_and_set(input logic desc, input logic mag);
    elem_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_DESCENDING;
    wr_data  <= desc;
    @(negedge clk);
    wr_index <= REG_BY_MAGNITUDE;
    wr_data  <= mag;
    @(negedge clk);
    wr_en    <= 1'b0;
    @(negedge clk);
    phases++;
  endtask

  task automatic send_vector(input int len, input logic flag_end, input int style);
    int i;
    for (i = 0; i < len; i++)
      send_elem(pick_value(style == 3 ? $urandom_range(0, 2) : style),
                flag_end && (i == len - 1));
    vectors++;
  endtask

  initial begin
    int   ph;
    int   nv;
    int   v;
    int   len;
    int   r;
    logic desc;
    logic mag;

    rst             = 1'b1;
    wr_en           = 1'b0;
    wr_index        = REG_DESCENDING;
    wr_data         = 1'b0;
    elem_ch.valid   = 1'b0;
    elem_ch.value   = '0;
    elem_ch.last_in = 1'b0;
    calm            = 1'b0;
    sent            = 0;
    vectors         = 0;
    phases          = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting: ascending, signed; extremes and a duplicated minimum
    send_elem(KEY_MAX, 1'b0);
    send_elem(KEY_MIN, 1'b0);
    send_elem(0, 1'b0);
    send_elem(-1, 1'b0);
    send_elem(1, 1'b0);
    send_elem(KEY_MIN, 1'b1);
    send_elem(5, 1'b1);
    vectors += 2;

    // descending magnitude: most negative saturates and ties with the maximum
    drain_and_set(1'b1, 1'b1);
    send_elem(KEY_MIN, 1'b0);
    send_elem(KEY_MAX, 1'b0);
    send_elem(KEY_MIN + 1, 1'b0);
    send_elem(3, 1'b0);
    send_elem(-3, 1'b0);
    send_elem(0, 1'b1);
    vectors++;

    drain_and_set(1'b0, 1'b1);
    send_elem(0, 1'b0);
    send_elem(KEY_MIN, 1'b0);
    send_elem(0, 1'b0);
    send_elem(7, 1'b0);
    send_elem(-7, 1'b1);
    vectors++;

    drain_and_set(1'b1, 1'b0);
    send_elem(1, 1'b0);
    send_elem(1, 1'b0);
    send_elem(-1, 1'b0);
    send_elem(KEY_MAX, 1'b0);
    send_elem(KEY_MIN, 1'b1);
    vectors++;

    ph = 0;
    while (sent < N_ITEMS) begin
      if (ph < 4) begin
        desc = ph[0];
        mag  = ph[1];
      end else begin
        desc = $urandom_range(0, 1);
        mag  = $urandom_range(0, 1);
      end
      drain_and_set(desc, mag);
      calm = ($urandom_range(0, 3) == 0);
      nv = $urandom_range(1, 4);
      for (v = 0; v < nv && sent < N_ITEMS; v++) begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          send_vector(CAP, 1'b0, 3);
        end else if (r == 1) begin
          send_vector(CAP, 1'b1, 3);
        end else if (r == 2) begin
          send_vector($urandom_range(9, CAP - 1), 1'b1, 3);
        end else begin
          len = $urandom_range(1, 8);
          send_vector(len, 1'b1, $urandom_range(0, 3));
        end
      end
      ph++;
    end
    calm = 1'b0;

    elem_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d elements in %0d vectors over %0d register settings", sent, vectors,
             phases + 1);
    $display("checked %0d sorted indices, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
